@@ hdl/wsl_pkg.sv @@
// Shared constants, types and helpers for the word split / sort block.
// No dependencies.
`timescale 1ns / 1ps

package wsl_pkg;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 64;
    localparam int CHAR_W       = 8;

    localparam int W_W       = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
    localparam int RAM_DEPTH = MAX_WORDS * MAX_WORD_LEN;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic              ovf;
        logic              nleft;
        logic              lend;
        logic              wend;
        logic              empty;
        logic [CHAR_W-1:0] ch;
    } t_result;

    // character store address of character k of word w
    function automatic logic [ADDR_W-1:0] f_addr(input logic [W_W-1:0] w,
                                                 input logic [LEN_W-1:0] k);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(w) * ADDR_W'(MAX_WORD_LEN);
        return base + ADDR_W'(k);
    endfunction

endpackage

@@ hdl/wsl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/wsl_front.sv @@
// Input side: accepts transfers, drops unused op codes, queues commands.
// Depends on wsl_pkg.
`timescale 1ns / 1ps

module wsl_front
    import wsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [1:0]        i_op,
    input  logic [CHAR_W-1:0] i_ch,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_s_tready  = (r_cnt != 2'd2);
    assign w_push      = i_s_tvalid && o_s_tready &&
                         (i_op == OP_PUSH || i_op == OP_EOL || i_op == OP_READ);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{op: i_op, ch: i_ch};
        end
    end

endmodule

@@ hdl/wsl_back.sv @@
// Execution side: word store, insertion sort sequencer, readout, output register.
// Depends on wsl_pkg and wsl_ram.
`timescale 1ns / 1ps

module wsl_back
    import wsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_SI   = 3'd2;
    localparam logic [2:0] S_SJ   = 3'd3;
    localparam logic [2:0] S_CA   = 3'd4;
    localparam logic [2:0] S_CB   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_wc, n_wc, r_rw, n_rw, r_i, n_i, r_j, n_j;
    logic [LEN_W-1:0]  r_cl, n_cl, r_rc, n_rc, r_klen, n_klen, r_k, n_k;
    logic [LEN_W-1:0]  r_rlen, n_rlen;
    logic              r_sr, n_sr, r_of, n_of, r_ov, n_ov;
    logic [LEN_W-1:0]  r_len [MAX_WORDS];
    logic [LEN_W-1:0]  n_len [MAX_WORDS];
    logic [W_W-1:0]    r_ord [MAX_WORDS];
    logic [W_W-1:0]    n_ord [MAX_WORDS];
    logic [W_W-1:0]    r_key, n_key, r_b, n_b;
    logic [CHAR_W-1:0] r_ca, n_ca;
    t_result           r_out, n_out;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [CHAR_W-1:0] w_rdata;

    // line state after the "new line discards pending output" rule
    logic [CNT_W-1:0]  b_wc;
    logic [LEN_W-1:0]  b_cl;
    logic              b_of;
    logic [W_W-1:0]    s_w, s_b;
    logic [LEN_W-1:0]  s_bl;
    logic              s_place, s_before, s_empty, s_wend, s_lend;

    wsl_ram #(.WIDTH(CHAR_W), .DEPTH(RAM_DEPTH)) u_chars (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.ch),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_cmd_ready = (r_state == S_IDLE) && (i_cmd.op != OP_READ || !r_ov);
    assign o_res_valid = r_ov;
    assign o_res       = r_out;

    assign b_wc = r_sr ? '0 : r_wc;
    assign b_cl = r_sr ? '0 : r_cl;
    assign b_of = r_sr ? 1'b0 : r_of;

    always_comb begin
        n_state = r_state;
        n_wc = r_wc;  n_cl = r_cl;  n_rw = r_rw;  n_rc = r_rc;
        n_sr = r_sr;  n_of = r_of;
        n_i = r_i;  n_j = r_j;  n_key = r_key;  n_klen = r_klen;
        n_b = r_b;  n_k = r_k;  n_ca = r_ca;  n_rlen = r_rlen;
        n_len = r_len;
        n_ord = r_ord;
        n_ov  = r_ov && !i_res_ready;
        n_out = r_out;
        w_we = 1'b0;
        w_waddr = '0;
        w_raddr = '0;
        s_w = r_ord[r_rw[W_W-1:0]];
        s_b = r_ord[W_W'(r_j - 1'b1)];
        s_bl = r_len[s_b];
        s_place = 1'b0;
        s_before = 1'b0;
        s_empty = (r_rlen == '0);
        s_wend = s_empty || (({1'b0, r_rc} + 1'b1) >= {1'b0, r_rlen});
        s_lend = s_wend && (({1'b0, r_rw} + 1'b1) >= {1'b0, r_wc});

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    case (i_cmd.op)
                        OP_PUSH, OP_EOL: begin
                            n_wc = b_wc;  n_cl = b_cl;  n_of = b_of;
                            n_sr = 1'b0;  n_rw = '0;   n_rc = '0;
                            if (i_cmd.op == OP_EOL || i_cmd.ch == SPACE_CHAR) begin
                                // close the word being built
                                if (b_wc < CNT_W'(MAX_WORDS)) begin
                                    n_len[b_wc[W_W-1:0]] = b_cl;
                                    n_wc = b_wc + 1'b1;
                                end else begin
                                    n_of = 1'b1;
                                end
                                n_cl = '0;
                                if (i_cmd.op == OP_EOL) begin
                                    n_sr = 1'b1;
                                    for (int x = 0; x < MAX_WORDS; x++) begin
                                        n_ord[x] = W_W'(x);
                                    end
                                    n_i = CNT_W'(1);
                                    n_state = S_SI;
                                end
                            end else if (b_cl < LEN_W'(MAX_WORD_LEN)) begin
                                if (b_wc < CNT_W'(MAX_WORDS)) begin
                                    w_we = 1'b1;
                                    w_waddr = f_addr(b_wc[W_W-1:0], b_cl);
                                end
                                n_cl = b_cl + 1'b1;
                            end else begin
                                n_of = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (!r_sr || r_rw >= r_wc) begin
                                n_ov  = 1'b1;
                                n_out = '{ovf: r_of, nleft: 1'b1, lend: 1'b0,
                                          wend: 1'b0, empty: 1'b0, ch: '0};
                            end else begin
                                n_rlen  = r_len[s_w];
                                w_raddr = f_addr(s_w, r_rc);
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_ov  = 1'b1;
                n_out = '{ovf: r_of, nleft: 1'b0, lend: s_lend, wend: s_wend,
                          empty: s_empty, ch: s_empty ? '0 : w_rdata};
                if (s_lend) begin
                    n_wc = '0;  n_cl = '0;  n_rw = '0;  n_rc = '0;
                    n_sr = 1'b0;  n_of = 1'b0;
                end else if (s_wend) begin
                    n_rw = r_rw + 1'b1;
                    n_rc = '0;
                end else begin
                    n_rc = r_rc + 1'b1;
                end
                n_state = S_IDLE;
            end
            S_SI: begin
                if (r_i >= r_wc) begin
                    n_state = S_IDLE;
                end else begin
                    n_key   = r_ord[r_i[W_W-1:0]];
                    n_klen  = r_len[r_ord[r_i[W_W-1:0]]];
                    n_j     = r_i;
                    n_state = S_SJ;
                end
            end
            S_SJ: begin
                if (r_j == '0) begin
                    n_ord[0] = r_key;
                    n_i = r_i + 1'b1;
                    n_state = S_SI;
                end else if (r_klen != s_bl) begin
                    s_place  = 1'b1;
                    s_before = (r_klen > s_bl);
                end else if (r_klen == '0) begin
                    s_place = 1'b1;
                end else begin
                    n_b = s_b;
                    n_k = '0;
                    w_raddr = f_addr(r_key, '0);
                    n_state = S_CA;
                end
            end
            S_CA: begin
                n_ca = w_rdata;
                w_raddr = f_addr(r_b, r_k);
                n_state = S_CB;
            end
            S_CB: begin
                s_b = r_b;
                if (r_ca != w_rdata) begin
                    s_place  = 1'b1;
                    s_before = (r_ca < w_rdata);
                end else if (r_k + 1'b1 == r_klen) begin
                    s_place = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                    w_raddr = f_addr(r_key, r_k + 1'b1);
                    n_state = S_CA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one insertion step: shift the compared word up, or drop the key in
        if (s_place) begin
            if (s_before) begin
                n_ord[r_j[W_W-1:0]] = s_b;
                n_j = r_j - 1'b1;
                n_state = S_SJ;
            end else begin
                n_ord[r_j[W_W-1:0]] = r_key;
                n_i = r_i + 1'b1;
                n_state = S_SI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wc <= '0;  r_cl <= '0;  r_rw <= '0;  r_rc <= '0;
            r_sr <= 1'b0;  r_of <= 1'b0;  r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wc <= n_wc;  r_cl <= n_cl;  r_rw <= n_rw;  r_rc <= n_rc;
            r_sr <= n_sr;  r_of <= n_of;  r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_j <= n_j;  r_key <= n_key;  r_klen <= n_klen;
        r_b <= n_b;  r_k <= n_k;  r_ca <= n_ca;  r_rlen <= n_rlen;
        r_len <= n_len;
        r_ord <= n_ord;
        r_out <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_wc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wc <= CNT_W'(MAX_WORDS))
        else $error("word count beyond capacity");
    a_cl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cl <= LEN_W'(MAX_WORD_LEN))
        else $error("word length beyond limit");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> !r_ov)
        else $error("readout would overwrite a waiting result");
    a_sort_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SJ |-> (r_j <= r_i && r_i < r_wc))
        else $error("insertion index out of range");
    a_read_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> (r_sr && r_rw < r_wc))
        else $error("readout without sorted list");
`endif

endmodule

@@ hdl/word_split_length_lex_sort.sv @@
// Top level of the word splitter / length-then-lexicographic sorter.
// Depends on wsl_pkg, wsl_front, wsl_back (which holds wsl_ram).
`timescale 1ns / 1ps
//
// Usage:
//   Slave channel: one transfer per item. tuser carries op (0 push byte,
//   1 end of line and sort, 2 read), tdata carries the byte for a push.
//   Op 3 is swallowed without effect. Space bytes split words.
//   Master channel: one transfer per read. tdata is the character, tlast
//   marks the last character of the last word, tuser holds the flags.
// Timing:
//   A two-entry command queue sits in front of the execution sequencer.
//   Pushes and reads with nothing pending execute in the idle state; a read of a
//   stored character passes through a read state (registered character memory read).
//   End of line runs an insertion sort over the stored words: an outer step per
//   word, a shift per word moved up, plus a read and a compare state per compared
//   character when lengths tie.
// Reset: synchronous active low; clears queue, counts and flags. Stored
//   characters are not cleared and their values are never used before being written.
// Stall: a result waits in the output register; the queue keeps taking
//   items until full, and the sequencer holds a read until the register is free.

module word_split_length_lex_sort
    import wsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [CHAR_W-1:0] i_s_tdata,   // [7:0] char_in
    input  logic [1:0]        i_s_tuser,   // [1:0] op
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [CHAR_W-1:0] o_m_tdata,   // [7:0] out_char
    output logic              o_m_tlast,   // list_end
    output logic [3:0]        o_m_tuser    // [0] empty_word [1] word_end
                                           // [2] nothing_left [3] overflowed
);

    logic    w_cmd_valid, w_cmd_ready;
    t_cmd    w_cmd;
    t_result w_res;

    wsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_op        (i_s_tuser),
        .i_ch        (i_s_tdata),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    wsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (w_res)
    );

    assign o_m_tdata = w_res.ch;
    assign o_m_tlast = w_res.lend;
    assign o_m_tuser = {w_res.ovf, w_res.nleft, w_res.wend, w_res.empty};

endmodule

@@ sim/tb_word_split_length_lex_sort.sv @@
// Self-checking testbench for word_split_length_lex_sort: drives lines of bytes,
// end-of-line sorts and reads, predicts each read result and compares it.
// Depends on wsl_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

// Predicts read results and keeps the queue of expected results.
class wsl_sorter_model;
    logic [7:0] chars [wsl_pkg::MAX_WORDS][wsl_pkg::MAX_WORD_LEN];
    int unsigned lens [wsl_pkg::MAX_WORDS];
    int unsigned order [wsl_pkg::MAX_WORDS];
    int unsigned n_words, cur_len, rd_word, rd_char;
    bit ready, ovf;
    wsl_pkg::t_result pending[$];
    int n_errors;

    function void clear_line();
        n_words = 0; cur_len = 0; rd_word = 0; rd_char = 0;
        ready = 0; ovf = 0;
    endfunction

    function void close_word();
        if (n_words < wsl_pkg::MAX_WORDS) begin
            lens[n_words] = cur_len;
            n_words++;
        end else begin
            ovf = 1;
        end
        cur_len = 0;
    endfunction

    // longer first, then ascending bytes
    function bit ranks_ahead(int unsigned a, int unsigned b);
        if (lens[a] != lens[b]) return lens[a] > lens[b];
        for (int k = 0; k < lens[a]; k++)
            if (chars[a][k] != chars[b][k]) return chars[a][k] < chars[b][k];
        return 0;
    endfunction

    function void sort_line();
        int unsigned j, key;
        for (int i = 0; i < n_words; i++) order[i] = i;
        for (int i = 1; i < n_words; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && ranks_ahead(key, order[j-1])) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] ch);
        wsl_pkg::t_result r;
        int unsigned w;
        if (op == wsl_pkg::OP_PUSH || op == wsl_pkg::OP_EOL) begin
            if (ready) clear_line();
            if (op == wsl_pkg::OP_EOL) begin
                close_word();
                sort_line();
                rd_word = 0; rd_char = 0; ready = 1;
            end else if (ch == wsl_pkg::SPACE_CHAR) begin
                close_word();
            end else if (cur_len < wsl_pkg::MAX_WORD_LEN) begin
                if (n_words < wsl_pkg::MAX_WORDS) chars[n_words][cur_len] = ch;
                cur_len++;
            end else begin
                ovf = 1;
            end
        end else if (op == wsl_pkg::OP_READ) begin
            r = '0;
            r.ovf = ovf;
            if (!ready || rd_word >= n_words) begin
                r.nleft = 1;
            end else begin
                w = order[rd_word];
                r.empty = (lens[w] == 0);
                if (!r.empty) r.ch = chars[w][rd_char];
                r.wend = r.empty || (rd_char + 1 >= lens[w]);
                r.lend = r.wend && (rd_word + 1 >= n_words);
                if (r.lend) clear_line();
                else if (r.wend) begin rd_word++; rd_char = 0; end
                else rd_char++;
            end
            pending.push_back(r);
        end
    endfunction

    function void check_result(wsl_pkg::t_result got);
        wsl_pkg::t_result exp;
        if (pending.size() == 0) begin
            $error("unexpected result transfer %h", got);
            n_errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.ch !== exp.ch) begin
            $error("out_char exp %h got %h", exp.ch, got.ch); n_errors++;
        end
        if (got.empty !== exp.empty) begin
            $error("empty_word exp %b got %b", exp.empty, got.empty); n_errors++;
        end
        if (got.wend !== exp.wend) begin
            $error("word_end exp %b got %b", exp.wend, got.wend); n_errors++;
        end
        if (got.lend !== exp.lend) begin
            $error("list_end exp %b got %b", exp.lend, got.lend); n_errors++;
        end
        if (got.nleft !== exp.nleft) begin
            $error("nothing_left exp %b got %b", exp.nleft, got.nleft); n_errors++;
        end
        if (got.ovf !== exp.ovf) begin
            $error("overflowed exp %b got %b", exp.ovf, got.ovf); n_errors++;
        end
    endfunction
endclass

module tb_word_split_length_lex_sort;
    import wsl_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_s_tvalid = 0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = '0;
    logic [1:0] i_s_tuser = '0;
    logic       o_m_tvalid;
    logic       i_m_tready = 0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic [3:0] o_m_tuser;

    wsl_sorter_model sorter;
    int send_idle_pct = 0;   // sender gap chance, percent
    int recv_stall_pct = 0;  // receiver stall chance, percent
    int hold_off = 0;        // cycles of forced receiver hold-off
    int n_sent = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    word_split_length_lex_sort u_top (.*);

    // Receiver: random tready, optional long hold-off, check each result transfer.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            r.ch = o_m_tdata;
            r.empty = o_m_tuser[0];
            r.wend = o_m_tuser[1];
            r.nleft = o_m_tuser[2];
            r.ovf = o_m_tuser[3];
            r.lend = o_m_tlast;
            sorter.check_result(r);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One item transfer; random idle cycles ahead of it.
    task automatic send_item(logic [1:0] op, logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= ch;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sorter.note_input(op, ch);
        n_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (sorter.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        case ($urandom_range(9))
            0: c = 8'($urandom_range(255));
            1: c = 8'd0;
            default: c = 8'($urandom_range(99, 97));  // few letters: many ties
        endcase
        if (c == SPACE_CHAR) c = 8'd33;
        return c;
    endfunction

    // A random line then enough reads to drain it, sometimes cut short.
    task automatic random_line();
        int n_w, len, total;
        n_w = ($urandom_range(19) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 1);
        total = 0;
        for (int w = 0; w < n_w; w++) begin
            len = ($urandom_range(29) == 0) ? $urandom_range(70, 60) : $urandom_range(4);
            for (int k = 0; k < len; k++) send_item(OP_PUSH, word_byte());
            if (w != n_w - 1) send_item(OP_PUSH, SPACE_CHAR);
            total += (len > 0) ? len : 1;
        end
        send_item(OP_EOL, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) total = $urandom_range(total);
        else total += $urandom_range(1);
        for (int i = 0; i < total; i++) send_item(OP_READ, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) send_item(2'd3, 8'($urandom_range(255)));
    endtask

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sorter = new();
        sorter.clear_line();
        sorter.n_errors = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: read with nothing pending, empty line, op 3, byte extremes.
        send_item(OP_READ, 8'h00);
        send_item(OP_EOL, 8'hFF);
        send_item(OP_READ, 8'h00);
        send_item(OP_READ, 8'h00);
        send_item(2'd3, 8'hAA);
        send_item(OP_PUSH, 8'hFF);
        send_item(OP_PUSH, 8'h01);
        send_item(OP_PUSH, SPACE_CHAR);
        send_item(OP_PUSH, SPACE_CHAR);
        send_item(OP_PUSH, 8'h00);
        send_item(OP_PUSH, 8'h7F);
        send_item(OP_PUSH, SPACE_CHAR);
        send_item(OP_PUSH, 8'h80);
        send_item(OP_EOL, 8'h55);
        for (int i = 0; i < 6; i++) send_item(OP_READ, 8'h00);
        // push after a fully read line starts a new one
        send_item(OP_PUSH, 8'h41);
        send_item(OP_EOL, 8'h00);
        send_item(OP_READ, 8'hFF);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 48 : 19) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 48 : 19) : 0;
            if (phase == 1) hold_off = 300;  // back-pressure the whole queue
            while (n_sent < 25 + (phase + 1) * 340) random_line();
            wait_drained();
        end
        repeat (50) @(posedge i_clk);

        if (sorter.n_errors == 0 && sorter.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
